[src/tccw_pkg.sv]
// shared types and constants for the text console cursor writer
// no dependencies; imported by every module of the block
package tccw_pkg;

    // control and printable codes of the character stream
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    // screen geometry defaults
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 24;
    localparam int TAB_STOP_DEF = 8;

    // most writes one tab may cause, and its counter width
    localparam int RESULT_LIMIT = 8;
    localparam int TAB_CNT_W    = 3;

    // cell index is computed at the width of the largest screen, then cut
    localparam int IDX_FULL_W = 12;
    localparam int IDX_W      = 11;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // stream widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [2:0] {
        K_PRINT,
        K_NEWLINE,
        K_RETURN,
        K_TAB,
        K_BKSP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  glyph;
        logic [7:0]  attr;
    } t_cmd;

    // queue status seen by the front
    typedef struct packed {
        logic full;
    } t_q_stat;

endpackage

[src/tccw_front.sv]
// front end: accepts character requests and classifies them into commands
// depends on tccw_pkg
module tccw_front (
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [7:0] char_code, [15:8] attribute
    input  logic [tccw_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  tccw_pkg::t_q_stat                  i_q_stat,
    output logic                               o_push,
    output tccw_pkg::t_cmd                     o_cmd
);
    import tccw_pkg::*;

    logic [7:0] w_char;
    logic [7:0] w_attr;
    t_kind      w_kind;

    assign w_char = i_s_tdata[7:0];
    assign w_attr = i_s_tdata[15:8];

    // take a request whenever the queue has room
    assign o_s_tready = i_rst_n && !i_q_stat.full;
    assign o_push     = i_s_tvalid && o_s_tready;

    // classify the character byte
    always_comb begin
        case (w_char)
            CH_NEWLINE:   w_kind = K_NEWLINE;
            CH_RETURN:    w_kind = K_RETURN;
            CH_TAB:       w_kind = K_TAB;
            CH_BACKSPACE: w_kind = K_BKSP;
            default:      w_kind = K_PRINT;
        endcase
    end

    assign o_cmd.kind  = w_kind;
    assign o_cmd.glyph = w_char;
    assign o_cmd.attr  = w_attr;

endmodule

[src/tccw_queue.sv]
// short command queue between the front and back ends
// depends on tccw_pkg
module tccw_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tccw_pkg::t_cmd      i_cmd,
    output tccw_pkg::t_q_stat   o_q_stat,
    output logic                o_valid,
    output tccw_pkg::t_cmd      o_cmd,
    input  logic                i_pop
);
    import tccw_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               w_do_pop;

    assign w_do_pop       = i_pop && (r_count != '0);
    assign o_valid        = (r_count != '0);
    assign o_cmd          = r_mem[r_rd_ptr];
    assign o_q_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[src/tccw_back.sv]
// back end: keeps the cursor, runs commands and drives the write stream
// depends on tccw_pkg
module tccw_back #(
    parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tccw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tccw_pkg::TAB_STOP_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cmd_valid,
    input  tccw_pkg::t_cmd                     i_cmd,
    output logic                               o_pop,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [10:0] cell_index, [18:11] glyph, [26:19] colour, [27] colour_write
    output logic [tccw_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                               o_m_tlast
);
    import tccw_pkg::*;

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = $clog2(COLUMNS);
    localparam int PW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
    localparam logic [PW-1:0] PH_LAST  = PW'(TAB_STOP - 1);
    localparam logic [PW-1:0] PH_EOL   = PW'((COLUMNS - 1) % TAB_STOP);

    // cursor, with its column kept modulo the tab stop as well
    logic [RW-1:0]        r_row,  n_row;
    logic [CW-1:0]        r_col,  n_col;
    logic [PW-1:0]        r_ph,   n_ph;
    // tab in progress
    logic                 r_tab_busy, n_tab_busy;
    logic [7:0]           r_tab_attr, n_tab_attr;
    logic [TAB_CNT_W-1:0] r_tab_cnt,  n_tab_cnt;
    // output register
    logic                 r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic                 r_out_last,  n_out_last;

    logic                 w_slot;
    logic                 w_pop;
    logic [RW-1:0]        w_nl_row;
    logic [RW-1:0]        w_adv_row;
    logic [CW-1:0]        w_adv_col;
    logic [PW-1:0]        w_adv_ph;
    logic [RW-1:0]        w_bk_row;
    logic [CW-1:0]        w_bk_col;
    logic [PW-1:0]        w_bk_ph;
    logic                 w_at_home;
    logic                 w_use_bk;
    logic [RW-1:0]        w_e_row;
    logic [CW-1:0]        w_e_col;
    logic [IDX_FULL_W-1:0] w_idx_full;
    logic [IDX_W-1:0]     w_idx;

    // output slot frees up when the held write is taken
    assign w_slot = !r_out_valid || i_m_tready;

    // next row with wrap, no scroll
    assign w_nl_row = (r_row == ROW_LAST) ? '0 : r_row + 1'b1;

    // cursor after writing one cell
    always_comb begin
        if (r_col == COL_LAST) begin
            w_adv_row = w_nl_row;
            w_adv_col = '0;
            w_adv_ph  = '0;
        end else begin
            w_adv_row = r_row;
            w_adv_col = r_col + 1'b1;
            w_adv_ph  = (r_ph == PH_LAST) ? '0 : r_ph + 1'b1;
        end
    end

    // cursor after one backspace
    always_comb begin
        if (r_col != '0) begin
            w_bk_row = r_row;
            w_bk_col = r_col - 1'b1;
            w_bk_ph  = (r_ph == '0) ? PH_LAST : r_ph - 1'b1;
        end else begin
            w_bk_row = r_row - 1'b1;
            w_bk_col = COL_LAST;
            w_bk_ph  = PH_EOL;
        end
    end

    assign w_at_home = (r_row == '0) && (r_col == '0);

    // cell index of the write: current cursor, or the stepped-back one
    assign w_use_bk   = !r_tab_busy && (i_cmd.kind == K_BKSP);
    assign w_e_row    = w_use_bk ? w_bk_row : r_row;
    assign w_e_col    = w_use_bk ? w_bk_col : r_col;
    assign w_idx_full = IDX_FULL_W'(w_e_row) * IDX_FULL_W'(COLUMNS) + IDX_FULL_W'(w_e_col);
    assign w_idx      = w_idx_full[IDX_W-1:0];

    // command sequencer
    always_comb begin
        logic [7:0]           v_attr;
        logic [TAB_CNT_W-1:0] v_cnt;
        logic                 v_last;

        n_row       = r_row;
        n_col       = r_col;
        n_ph        = r_ph;
        n_tab_busy  = r_tab_busy;
        n_tab_attr  = r_tab_attr;
        n_tab_cnt   = r_tab_cnt;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        w_pop       = 1'b0;
        v_attr      = r_tab_attr;
        v_cnt       = r_tab_cnt;
        v_last      = 1'b0;

        if (w_slot && (r_tab_busy || i_cmd_valid)) begin
            if (!r_tab_busy) begin
                w_pop  = 1'b1;
                v_attr = i_cmd.attr;
                v_cnt  = '0;
            end
            if (r_tab_busy || i_cmd.kind == K_TAB) begin
                // one space of a tab
                v_last      = (w_adv_ph == '0) || (v_cnt == TAB_CNT_W'(RESULT_LIMIT - 1));
                n_out_valid = 1'b1;
                n_out_data  = OUT_DATA_W'({1'b1, v_attr, CH_SPACE, w_idx});
                n_out_last  = v_last;
                n_row       = w_adv_row;
                n_col       = w_adv_col;
                n_ph        = w_adv_ph;
                n_tab_busy  = !v_last;
                n_tab_attr  = v_attr;
                n_tab_cnt   = v_cnt + 1'b1;
            end else begin
                case (i_cmd.kind)
                    K_NEWLINE: begin
                        n_row = w_nl_row;
                        n_col = '0;
                        n_ph  = '0;
                    end
                    K_RETURN: begin
                        n_col = '0;
                        n_ph  = '0;
                    end
                    K_BKSP: begin
                        if (!w_at_home) begin
                            n_out_valid = 1'b1;
                            n_out_data  = OUT_DATA_W'({1'b0, 8'h00, CH_SPACE, w_idx});
                            n_out_last  = 1'b1;
                            n_row       = w_bk_row;
                            n_col       = w_bk_col;
                            n_ph        = w_bk_ph;
                        end
                    end
                    default: begin
                        // printable character
                        n_out_valid = 1'b1;
                        n_out_data  = OUT_DATA_W'({1'b1, i_cmd.attr, i_cmd.glyph, w_idx});
                        n_out_last  = 1'b1;
                        n_row       = w_adv_row;
                        n_col       = w_adv_col;
                        n_ph        = w_adv_ph;
                    end
                endcase
            end
        end
    end

    // state and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_ph        <= '0;
            r_tab_busy  <= 1'b0;
            r_tab_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_row       <= n_row;
            r_col       <= n_col;
            r_ph        <= n_ph;
            r_tab_busy  <= n_tab_busy;
            r_tab_cnt   <= n_tab_cnt;
            r_out_valid <= n_out_valid;
        end
        r_tab_attr <= n_tab_attr;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_pop      = w_pop;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    // cursor stays on screen
    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= COL_LAST) && (r_row <= ROW_LAST))
        else $error("cursor left the screen");

    // no command is taken while a tab is still writing spaces
    a_no_pop_in_tab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tab_busy |-> !w_pop)
        else $error("command popped during tab");

    // a tab in progress never goes past the write limit
    a_tab_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tab_busy |-> (r_tab_cnt != '0))
        else $error("tab count out of range");

    // a character-only write carries a zero colour
    a_colour_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data[27]) |-> (r_out_data[26:19] == 8'h00))
        else $error("colour set on character-only write");

    // mid-tab writes are never marked last
    a_tab_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_tab_busy) |-> !r_out_last)
        else $error("tab write marked last while tab continues");
`endif

endmodule

[src/text_console_cursor_writer_unit.sv]
// top level of the text console cursor writer
// depends on tccw_pkg, tccw_front, tccw_queue and tccw_back

// Takes one character request per cycle (char_code, attribute) and produces
// write requests for a text-mode cell buffer of ROWS by COLUMNS cells; the
// cell sits at byte address 0xB8000 + 2 * cell_index, character in the even
// byte and attribute in the odd one. The front end accepts a request every
// cycle while its four-entry command queue has room. The back end, which
// owns the cursor, runs one command at a time: a printable character or a
// backspace gives one write, newline, carriage return and a backspace at home
// give none, and a tab gives one write per cycle while the output is free,
// up to the next tab stop, at most min(TAB_STOP, 8) writes. Throughput is set
// by the cursor loop and the output register, which holds a write until taken.
module text_console_cursor_writer_unit #(
    parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tccw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tccw_pkg::TAB_STOP_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [7:0] char_code, [15:8] attribute
    input  logic [tccw_pkg::IN_DATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [10:0] cell_index, [18:11] glyph, [26:19] colour, [27] colour_write
    output logic [tccw_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // last_write
    output logic                               o_m_tlast
);
    import tccw_pkg::*;

    t_q_stat w_q_stat;
    logic    w_push;
    t_cmd    w_push_cmd;
    logic    w_q_valid;
    t_cmd    w_q_cmd;
    logic    w_pop;

    // request intake and classification
    tccw_front u_front (
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    // command queue
    tccw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .o_q_stat (w_q_stat),
        .o_valid  (w_q_valid),
        .o_cmd    (w_q_cmd),
        .i_pop    (w_pop)
    );

    // cursor and write generation
    tccw_back #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
